[rtl/ohyst_pkg.sv]
// Shared types and constants for the orientation hysteresis table.
// No dependencies; imported by every module of the block except ohyst_ram.
`default_nettype none

package ohyst_pkg;

   localparam int CELLS      = 4096;
   localparam int CELL_W     = $clog2(CELLS);
   localparam int ANGLE_W    = 16;
   localparam int GLYPH_W    = 21;
   localparam int COUNT_W    = 13;
   localparam int MARGIN_W   = 16;
   localparam int EPOCH_W    = 8;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
   localparam logic [EPOCH_W-1:0] EPOCH_MAX   = {EPOCH_W{1'b1}};
   localparam logic [EPOCH_W-1:0] TAG_EMPTY   = '0;

   localparam logic [ANGLE_W-1:0] HALF_TURN = ANGLE_W'(1) << (ANGLE_W - 1);
   localparam logic [COUNT_W-1:0] CELLS_MAX = COUNT_W'(CELLS);
   localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(4096);

   // request codes
   localparam logic [1:0] REQ_CHOOSE    = 2'd0;
   localparam logic [1:0] REQ_CLEAR_ONE = 2'd1;
   localparam logic [1:0] REQ_CLEAR_ALL = 2'd2;

   // register indexes, taken from paddr[2]
   localparam logic REG_ANGLE_MARGIN = 1'b0;
   localparam logic REG_CELL_COUNT   = 1'b1;

   typedef struct packed {
      logic [1:0]         req_type;
      logic [11:0]        cell_index;
      logic [GLYPH_W-1:0] new_glyph;
      logic [ANGLE_W-1:0] new_angle;
   } req_item_type;

   typedef struct packed {
      logic [GLYPH_W-1:0] out_glyph;
      logic [ANGLE_W-1:0] out_angle;
      logic               prior_kept;
      logic               index_error;
   } rsp_item_type;

   typedef struct packed {
      logic [EPOCH_W-1:0] tag;
      logic [GLYPH_W-1:0] glyph;
      logic [ANGLE_W-1:0] angle;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic [MARGIN_W-1:0] angle_margin;
      logic [COUNT_W-1:0]  cell_count;
      logic                count_change;
   } cfg_type;

   typedef struct packed {
      logic              busy;
      logic              wr_en;
      logic [CELL_W-1:0] wr_addr;
   } sweep_type;

   typedef enum logic {
      SWEEP_IDLE,
      SWEEP_RUN
   } sweep_state_type;

endpackage

`default_nettype wire

[rtl/ohyst_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ohyst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

[rtl/ohyst_csr.sv]
// Configuration registers (angle margin, cell count) behind an APB-style port.
// Depends on ohyst_pkg.
`default_nettype none

module ohyst_csr
   import ohyst_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready,
   output cfg_type                    cfg
);

   logic [MARGIN_W-1:0] margin_ff, margin_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic                wr_beat;
   logic                count_change;

   assign csr_pready = 1'b1;
   assign wr_beat    = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      margin_in    = margin_ff;
      count_in     = count_ff;
      count_change = 1'b0;
      if (wr_beat) begin
         case (csr_paddr[2])
            REG_ANGLE_MARGIN: margin_in = csr_pwdata[MARGIN_W-1:0];
            REG_CELL_COUNT: begin
               count_in     = csr_pwdata[COUNT_W-1:0];
               count_change = (csr_pwdata[COUNT_W-1:0] != count_ff);
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         margin_ff <= '0;
         count_ff  <= COUNT_RESET;
      end else begin
         margin_ff <= margin_in;
         count_ff  <= count_in;
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_ANGLE_MARGIN: csr_prdata = CSR_DATA_W'(margin_ff);
         REG_CELL_COUNT:   csr_prdata = CSR_DATA_W'(count_ff);
         default:          csr_prdata = '0;
      endcase
   end

   assign cfg.angle_margin = margin_ff;
   assign cfg.cell_count   = count_ff;
   assign cfg.count_change = count_change;

endmodule

`default_nettype wire

[rtl/ohyst_sweep.sv]
// Clearing pass sequencer: writes an empty tag to every table entry, one a cycle.
// Depends on ohyst_pkg. Runs after reset and whenever the epoch counter wraps.
`default_nettype none

module ohyst_sweep
   import ohyst_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   output sweep_type sweep
);

   sweep_state_type   state_ff, state_in;
   logic [CELL_W-1:0] addr_ff, addr_in;
   logic              last;

   assign last = (addr_ff == CELL_W'(CELLS - 1));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SWEEP_IDLE: if (start) state_in = SWEEP_RUN;
         SWEEP_RUN:  if (last && !start) state_in = SWEEP_IDLE;
         default:    state_in = SWEEP_IDLE;
      endcase
   end

   always_comb begin
      sweep.busy    = 1'b0;
      sweep.wr_en   = 1'b0;
      sweep.wr_addr = addr_ff;
      case (state_ff)
         SWEEP_IDLE: ;
         SWEEP_RUN: begin
            sweep.busy  = 1'b1;
            sweep.wr_en = 1'b1;
         end
         default: ;
      endcase
   end

   always_comb begin
      if (start) begin
         addr_in = '0;
      end else if (state_ff == SWEEP_RUN) begin
         addr_in = addr_ff + CELL_W'(1);
      end else begin
         addr_in = addr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SWEEP_RUN;
         addr_ff  <= '0;
      end else begin
         state_ff <= state_in;
         addr_ff  <= addr_in;
      end
   end

endmodule

`default_nettype wire

[rtl/orientation_hysteresis_table.sv]
// Per-cell glyph and orientation hysteresis table.
// A request is held in stage 1 and its result in the output register; one request per
// cycle while the result side keeps up. The table RAM is read on accept and written
// back as the request leaves stage 1; the last write is forwarded to the next request.
// A clearing pass runs with req_ready low after reset and every 255th clear-all or
// cell count change. Depends on ohyst_pkg, ohyst_ram, ohyst_csr and ohyst_sweep.
`default_nettype none

module orientation_hysteresis_table
   import ohyst_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire req_item_type          req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_item_type               rsp_data,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   cfg_type   cfg;
   sweep_type sweep;

   logic              req_beat;
   logic              s1_valid_ff, s1_valid_in;
   req_item_type      s1_req_ff;
   logic              s1_adv;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_item_type      rsp_data_ff, rsp_data_in;

   logic [EPOCH_W-1:0] epoch_ff, epoch_in;
   logic               bump;
   logic               pass_start;

   logic              lw_en_ff, lw_en_in;
   logic [CELL_W-1:0] lw_addr_ff, lw_addr_in;
   entry_type         lw_data_ff, lw_data_in;

   entry_type          rd_data;
   entry_type          entry;
   logic [CELL_W-1:0]  s1_addr;
   logic [COUNT_W-1:0] eff_count;
   logic               in_range;
   logic               is_choose, is_clear_one, is_clear_all;
   logic [ANGLE_W-1:0] diff, ang_dist, margin_eff;
   logic               keep;

   logic              item_wr;
   entry_type         item_wr_data;
   logic              ram_wr_en;
   logic [CELL_W-1:0] ram_wr_addr;
   entry_type         ram_wr_data;

   ohyst_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   ohyst_sweep u_sweep (
      .clock (clock),
      .reset (reset),
      .start (pass_start),
      .sweep (sweep)
   );

   ohyst_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CELLS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (req_beat),
      .rd_addr (req_data.cell_index[CELL_W-1:0]),
      .rd_data (rd_data)
   );

   // ---- stage 1: decide on the entry read at accept
   assign s1_addr      = s1_req_ff.cell_index[CELL_W-1:0];
   assign is_choose    = (s1_req_ff.req_type == REQ_CHOOSE);
   assign is_clear_one = (s1_req_ff.req_type == REQ_CLEAR_ONE);
   assign is_clear_all = (s1_req_ff.req_type == REQ_CLEAR_ALL);

   // forward the previous write; the RAM still returned the old word for it
   assign entry = (lw_en_ff && lw_addr_ff == s1_addr) ? lw_data_ff : rd_data;

   assign eff_count = (cfg.cell_count > CELLS_MAX) ? CELLS_MAX : cfg.cell_count;
   assign in_range  = (COUNT_W'(s1_req_ff.cell_index) < eff_count);

   assign diff       = entry.angle - s1_req_ff.new_angle;
   assign ang_dist   = (diff > HALF_TURN) ? (ANGLE_W'(0) - diff) : diff;
   assign margin_eff = (cfg.angle_margin > HALF_TURN) ? HALF_TURN : cfg.angle_margin;
   assign keep       = (entry.tag == epoch_ff) && (entry.glyph != s1_req_ff.new_glyph)
                       && (margin_eff != '0) && (ang_dist <= margin_eff);

   assign s1_adv = s1_valid_ff && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      rsp_data_in  = '0;
      item_wr      = 1'b0;
      item_wr_data = entry;
      if (is_choose || is_clear_one) begin
         if (!in_range) begin
            rsp_data_in.index_error = 1'b1;
         end else if (is_clear_one) begin
            item_wr          = 1'b1;
            item_wr_data.tag = TAG_EMPTY;
         end else begin
            item_wr = 1'b1;
            if (keep) begin
               rsp_data_in.out_glyph  = entry.glyph;
               rsp_data_in.out_angle  = entry.angle;
               rsp_data_in.prior_kept = 1'b1;
            end else begin
               rsp_data_in.out_glyph = s1_req_ff.new_glyph;
               rsp_data_in.out_angle = s1_req_ff.new_angle;
            end
            item_wr_data.tag   = epoch_ff;
            item_wr_data.glyph = rsp_data_in.out_glyph;
            item_wr_data.angle = rsp_data_in.out_angle;
         end
      end
   end

   // ---- epoch: clear-all and a count change retire every entry at once
   assign bump       = (s1_adv && is_clear_all) || cfg.count_change;
   assign pass_start = bump && (epoch_ff == EPOCH_MAX);

   always_comb begin
      epoch_in = epoch_ff;
      if (pass_start) begin
         epoch_in = EPOCH_FIRST;
      end else if (bump) begin
         epoch_in = epoch_ff + EPOCH_W'(1);
      end
   end

   // ---- table write port: the clearing pass owns it while busy
   always_comb begin
      if (sweep.busy) begin
         ram_wr_en   = sweep.wr_en;
         ram_wr_addr = sweep.wr_addr;
         ram_wr_data = '0;
      end else begin
         ram_wr_en   = s1_adv && item_wr;
         ram_wr_addr = s1_addr;
         ram_wr_data = item_wr_data;
      end
   end

   always_comb begin
      lw_en_in   = lw_en_ff;
      lw_addr_in = lw_addr_ff;
      lw_data_in = lw_data_ff;
      if (sweep.busy) begin
         lw_en_in = 1'b0;
      end else if (s1_adv) begin
         lw_en_in   = item_wr;
         lw_addr_in = s1_addr;
         lw_data_in = item_wr_data;
      end
   end

   // ---- handshakes
   assign req_ready = !sweep.busy && !pass_start && (!s1_valid_ff || s1_adv);
   assign req_beat  = req_valid && req_ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_beat) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         epoch_ff     <= EPOCH_FIRST;
         lw_en_ff     <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         epoch_ff     <= epoch_in;
         lw_en_ff     <= lw_en_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         s1_req_ff <= req_data;
      end
      if (s1_adv) begin
         rsp_data_ff <= rsp_data_in;
      end
      lw_addr_ff <= lw_addr_in;
      lw_data_ff <= lw_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

[sim/tb_orientation_hysteresis_table.sv]
// Testbench for orientation_hysteresis_table: directed and random request beats,
// checked against an in-bench table predictor. Depends on ohyst_pkg and the block RTL.
`timescale 1ns / 100ps

module tb_orientation_hysteresis_table;
   import ohyst_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] ADDR_ANGLE_MARGIN = {REG_ANGLE_MARGIN, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ADDR_CELL_COUNT   = {REG_CELL_COUNT, 2'b00};
   localparam logic [1:0]            REQ_UNUSED        = 2'd3;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_item_type          req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_item_type          rsp_data;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // predicted table contents and register copies
   logic               held_valid [CELLS];
   logic [GLYPH_W-1:0] held_glyph [CELLS];
   logic [ANGLE_W-1:0] held_angle [CELLS];
   logic [MARGIN_W-1:0] margin_q;
   logic [COUNT_W-1:0]  cell_count_q;

   rsp_item_type pending_decisions [$];
   int           error_count   = 0;
   int           req_idle_pct  = 0;
   int           rsp_idle_pct  = 0;
   int           rsp_hold_left = 0;
   int           pool_base     = 0;
   logic [GLYPH_W-1:0] glyph_base = '0;

   orientation_hysteresis_table DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("*** FAILED ***");
      $finish;
   end

   // receiver: random stalls, plus a long hold-off when a test asks for one
   always @(negedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_hold_left = rsp_hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   function automatic int effective_cells();
      return (cell_count_q > CELLS) ? CELLS : int'(cell_count_q);
   endfunction

   function automatic rsp_item_type decide_cell(req_item_type r);
      rsp_item_type       res;
      logic [ANGLE_W-1:0] ang_dist;
      logic [ANGLE_W-1:0] limit;
      res = '0;
      limit = (margin_q > HALF_TURN) ? HALF_TURN : margin_q;
      if (r.req_type == REQ_CLEAR_ALL) begin
         for (int i = 0; i < CELLS; i++) held_valid[i] = 1'b0;
      end else if (r.req_type == REQ_CHOOSE || r.req_type == REQ_CLEAR_ONE) begin
         if (int'(r.cell_index) >= effective_cells()) begin
            res.index_error = 1'b1;
         end else if (r.req_type == REQ_CLEAR_ONE) begin
            held_valid[r.cell_index] = 1'b0;
         end else begin
            res.out_glyph = r.new_glyph;
            res.out_angle = r.new_angle;
            ang_dist = held_angle[r.cell_index] - r.new_angle;
            if (ang_dist > HALF_TURN) ang_dist = ANGLE_W'(0) - ang_dist;
            if (held_valid[r.cell_index] && held_glyph[r.cell_index] != r.new_glyph &&
                limit != 0 && ang_dist <= limit) begin
               res.out_glyph  = held_glyph[r.cell_index];
               res.out_angle  = held_angle[r.cell_index];
               res.prior_kept = 1'b1;
            end
            held_glyph[r.cell_index] = res.out_glyph;
            held_angle[r.cell_index] = res.out_angle;
            held_valid[r.cell_index] = 1'b1;
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_decisions.size() == 0) begin
            $error("result beat with no request waiting: %p", rsp_data);
            error_count++;
         end else begin
            want = pending_decisions.pop_front();
            if (rsp_data.out_glyph !== want.out_glyph) begin
               $error("out_glyph: expected %h, got %h", want.out_glyph, rsp_data.out_glyph);
               error_count++;
            end
            if (rsp_data.out_angle !== want.out_angle) begin
               $error("out_angle: expected %h, got %h", want.out_angle, rsp_data.out_angle);
               error_count++;
            end
            if (rsp_data.prior_kept !== want.prior_kept) begin
               $error("prior_kept: expected %b, got %b",
                      want.prior_kept, rsp_data.prior_kept);
               error_count++;
            end
            if (rsp_data.index_error !== want.index_error) begin
               $error("index_error: expected %b, got %b",
                      want.index_error, rsp_data.index_error);
               error_count++;
            end
         end
      end
   end

   // offer one request beat, idling first at the current rate; valid stays up
   task automatic send_request(req_item_type r);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      pending_decisions.push_back(decide_cell(r));
   endtask

   task automatic send_fields(logic [1:0] kind, logic [11:0] idx,
                              logic [GLYPH_W-1:0] glyph, logic [ANGLE_W-1:0] angle);
      req_item_type r;
      r.req_type   = kind;
      r.cell_index = idx;
      r.new_glyph  = glyph;
      r.new_angle  = angle;
      send_request(r);
   endtask

   // drop valid and wait until every outstanding result has come back
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_decisions.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] value);
      int waited;
      drain();
      // hold off while a clearing pass keeps the request side closed
      waited = 0;
      while (!req_ready && waited < 6000) begin
         @(posedge clock);
         waited++;
      end
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (addr == ADDR_ANGLE_MARGIN) begin
         margin_q = value[MARGIN_W-1:0];
      end else if (addr == ADDR_CELL_COUNT && value[COUNT_W-1:0] != cell_count_q) begin
         cell_count_q = value[COUNT_W-1:0];
         for (int i = 0; i < CELLS; i++) held_valid[i] = 1'b0;
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // mostly chooses on a small pool of cells, with angles near the stored one
   function automatic req_item_type make_request();
      req_item_type r;
      int           eff;
      int           span;
      int           reach;
      int           pick;
      eff  = effective_cells();
      pick = $urandom_range(0, 99);
      r.req_type   = REQ_CHOOSE;
      r.cell_index = 12'($urandom());
      r.new_glyph  = GLYPH_W'($urandom());
      r.new_angle  = ANGLE_W'($urandom());
      if (pick < 75 && eff > 0) begin
         span = (eff < 16) ? eff : 16;
         r.cell_index = 12'((pool_base % eff + $urandom_range(0, span - 1)) % eff);
         case ($urandom_range(0, 3))
            0: r.new_glyph = held_glyph[r.cell_index];
            1, 2: r.new_glyph = glyph_base + GLYPH_W'($urandom_range(0, 3));
            default: ;
         endcase
         if (held_valid[r.cell_index] && $urandom_range(0, 4) != 0) begin
            reach = ((margin_q > HALF_TURN) ? int'(HALF_TURN) : int'(margin_q)) + 2;
            r.new_angle = held_angle[r.cell_index] + ANGLE_W'($urandom_range(0, 2 * reach))
                          - ANGLE_W'(reach);
         end
      end else if (pick < 83 && eff > 0) begin
         r.req_type   = REQ_CLEAR_ONE;
         r.cell_index = 12'((pool_base % eff + $urandom_range(0, 15)) % eff);
      end else if (pick < 86) begin
         r.req_type = REQ_CLEAR_ALL;
      end else if (pick < 88) begin
         r.req_type = REQ_UNUSED;
      end else if (pick < 93) begin
         r.req_type = 2'($urandom_range(0, 1));
         if (eff < CELLS) r.cell_index = 12'($urandom_range(eff, CELLS - 1));
      end else begin
         r.req_type = 2'($urandom_range(0, 3));
      end
      return r;
   endfunction

   task automatic pick_random_config();
      logic [CSR_DATA_W-1:0] m;
      logic [CSR_DATA_W-1:0] c;
      case ($urandom_range(0, 6))
         0: m = 0;
         1: m = 1;
         2: m = 32768;
         3: m = 65535;
         default: m = $urandom_range(1, 4000);
      endcase
      case ($urandom_range(0, 7))
         0: c = 0;
         1: c = 1;
         2: c = 4096;
         3: c = 8191;
         4: c = $urandom_range(4097, 8190);
         5: c = $urandom_range(65, 4095);
         default: c = $urandom_range(2, 64);
      endcase
      write_reg(ADDR_ANGLE_MARGIN, m);
      write_reg(ADDR_CELL_COUNT, c);
      pool_base  = $urandom_range(0, CELLS - 1);
      glyph_base = GLYPH_W'($urandom());
   endtask

   task automatic test_keep_rules();
      write_reg(ADDR_ANGLE_MARGIN, 1000);
      write_reg(ADDR_CELL_COUNT, 4096);
      send_fields(REQ_CHOOSE, 12'd0, 21'h41, 16'd0);
      send_fields(REQ_CHOOSE, 12'd0, 21'h42, 16'd1000);      // distance equals margin
      send_fields(REQ_CHOOSE, 12'd0, 21'h42, 16'd64536);     // same distance, other side
      send_fields(REQ_CHOOSE, 12'd0, 21'h42, 16'd1001);      // one past margin
      send_fields(REQ_CHOOSE, 12'd0, 21'h42, 16'd1001);      // same glyph never kept
      send_fields(REQ_CHOOSE, 12'd4095, 21'h1FFFFF, 16'hFFFF);
      send_fields(REQ_CHOOSE, 12'd4095, 21'h0, 16'd999);     // wraps through zero
      write_reg(ADDR_ANGLE_MARGIN, 0);
      send_fields(REQ_CHOOSE, 12'd4095, 21'h1, 16'hFFFF);
   endtask

   task automatic test_clears();
      send_fields(REQ_CLEAR_ONE, 12'd4095, 21'h1FFFFF, 16'hFFFF);
      send_fields(REQ_CHOOSE, 12'd4095, 21'h2, 16'hFFFF);
      send_fields(REQ_CLEAR_ALL, 12'd4095, 21'h1FFFFF, 16'hFFFF);
      send_fields(REQ_CHOOSE, 12'd0, 21'h7, 16'd1001);
      send_fields(REQ_UNUSED, 12'($urandom()), GLYPH_W'($urandom()), ANGLE_W'($urandom()));
   endtask

   task automatic test_index_range();
      write_reg(ADDR_CELL_COUNT, 100);
      send_fields(REQ_CHOOSE, 12'd100, 21'h9, 16'd5);
      send_fields(REQ_CLEAR_ONE, 12'd100, 21'h0, 16'd0);
      send_fields(REQ_CHOOSE, 12'd99, 21'h9, 16'd5);
      write_reg(ADDR_CELL_COUNT, 0);
      send_fields(REQ_CHOOSE, 12'd0, 21'h9, 16'd5);
      send_fields(REQ_CLEAR_ONE, 12'd0, 21'h0, 16'd0);
      write_reg(ADDR_CELL_COUNT, 8191);
      send_fields(REQ_CHOOSE, 12'd4095, 21'h9, 16'd5);
   endtask

   task automatic test_margin_extremes();
      write_reg(ADDR_ANGLE_MARGIN, 65535);
      send_fields(REQ_CHOOSE, 12'd5, 21'h10, 16'd0);
      send_fields(REQ_CHOOSE, 12'd5, 21'h11, 16'd32768);
      write_reg(ADDR_ANGLE_MARGIN, 32768);
      send_fields(REQ_CHOOSE, 12'd5, 21'h12, 16'd32768);
      write_reg(ADDR_ANGLE_MARGIN, 32767);
      send_fields(REQ_CHOOSE, 12'd5, 21'h13, 16'd32768);
      write_reg(ADDR_CELL_COUNT, 1);
      send_fields(REQ_CHOOSE, 12'd0, 21'h14, 16'd7);
      send_fields(REQ_CHOOSE, 12'd1, 21'h14, 16'd7);
   endtask

   task automatic test_random_traffic(int n_items, int sender_pct, int receiver_pct);
      req_idle_pct = sender_pct;
      rsp_idle_pct = receiver_pct;
      for (int i = 0; i < n_items; i++) begin
         if (i % 120 == 0) pick_random_config();
         send_request(make_request());
      end
      drain();
   endtask

   // stall the result side long enough that the request side must close
   task automatic test_result_backpressure();
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      write_reg(ADDR_CELL_COUNT, 16);
      write_reg(ADDR_ANGLE_MARGIN, 500);
      pool_base = 0;
      @(posedge clock);
      rsp_hold_left = 300;
      repeat (40) send_request(make_request());
      drain();
   endtask

   task automatic test_sender_pause();
      req_idle_pct = 0;
      rsp_idle_pct = 30;
      repeat (12) send_request(make_request());
      drain();
      repeat (12) send_request(make_request());
      drain();
   endtask

   initial begin
      margin_q     = '0;
      cell_count_q = COUNT_RESET;
      for (int i = 0; i < CELLS; i++) begin
         held_valid[i] = 1'b0;
         held_glyph[i] = '0;
         held_angle[i] = '0;
      end
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      req_idle_pct = 23;
      rsp_idle_pct = 49;
      test_keep_rules();
      test_clears();
      test_index_range();
      test_margin_extremes();
      drain();

      test_random_traffic(600, 23, 49);
      test_random_traffic(600, 49, 23);
      test_result_backpressure();
      test_sender_pause();
      test_random_traffic(600, 0, 0);

      drain();
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
